// ===== design/mpfl_pkg.sv =====
package mpfl_pkg;

   localparam int FUNC_W     = 2;
   localparam int POOL_SEL_W = 3;
   localparam int SLOT_IDX_W = 10;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_INDEX_LSB  = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_USED_BIT   = RSP_INDEX_LSB + SLOT_IDX_W;
   localparam int RSP_COUNT_LSB  = RSP_USED_BIT + 1;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam func_type FUNC_ALLOC  = 2'd0;
   localparam func_type FUNC_FREE   = 2'd1;
   localparam func_type FUNC_LOOKUP = 2'd2;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_NOT_USED = 2'd2;
   localparam status_type ST_RANGE    = 2'd3;

endpackage

// ===== design/multi_pool_free_list_allocator.sv =====
// Slot allocator for NUM_POOLS pools of POOL_SIZE slots each.
// Request channel (req_): one transaction per operation: allocate, free or
// look up a slot of the selected pool. Response channel (rsp_): exactly one
// transaction per request, in request order, with status, slot, in-use bit
// and the pool's remaining free count.
// A request runs in steps: the accept cycle reads the per-pool table,
// the next cycle reads the free stack and in-use memories, and a final
// step forms the response and writes stack, in-use bit and pool table
// back. req_tready returns in the same cycle as the response becomes
// valid, so a new request is taken only once the last one has left its final step.
// Reset empties the response register and marks every pool table entry
// invalid; an invalid entry reads as a full pool. Stack entries below the
// lowest top a pool has reached, and in-use bits of slots never handed out,
// read as their reset values, so no clearing pass runs and requests are
// taken in the first cycle after reset.
// When the receiver stalls, a waiting response holds; the next request is
// still accepted and its work halts at the final step until the response
// register frees.
module multi_pool_free_list_allocator
   import mpfl_pkg::*;
#(
   parameter int NUM_POOLS = 8,
   parameter int POOL_SIZE = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // func[1:0], pool_sel[4:2], slot_index[14:5]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], granted_index[11:2], slot_in_use[12], free_count[23:13]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int CW = $clog2(POOL_SIZE + 1);
   localparam int SW = $clog2(POOL_SIZE);
   localparam int AW = $clog2(NUM_POOLS * POOL_SIZE);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TOP  = 2'd1;
   localparam logic [1:0] S_MEM  = 2'd2;

   logic [1:0]            state_ff, state_in;
   func_type              func_ff, func_in;
   logic [PW-1:0]         pool_ff, pool_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic                  pool_bad_ff, pool_bad_in;
   logic                  slot_bad_ff, slot_bad_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [CW-1:0]         top_ff, top_in;
   logic [CW-1:0]         low_ff, low_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   func_type              req_func;
   logic [POOL_SEL_W-1:0] req_pool;
   logic [SLOT_IDX_W-1:0] req_slot;
   logic                  req_accept;

   logic [CW-1:0] pt_top, pt_low;
   logic          pt_wr_en;
   logic [CW-1:0] pt_wr_top, pt_wr_low;

   logic          mem_rd_en;
   logic [AW-1:0] stk_rd_addr, use_rd_addr;
   logic [SW-1:0] stk_q;
   logic          use_q;
   logic          stk_wr_en, use_wr_en, use_wr_data;
   logic [AW-1:0] stk_wr_addr, use_wr_addr;
   logic [SW-1:0] stk_wr_data;

   logic [SW-1:0] slot_sw;
   logic [CW-1:0] rpos;
   logic          reset_region;
   logic [SW-1:0] got;
   logic          used;
   logic          finish;
   status_type    r_status;
   logic [SW-1:0] r_index;
   logic          r_used;
   logic [CW-1:0] r_count;

   assign req_func   = req_tdata[FUNC_W-1:0];
   assign req_pool   = req_tdata[FUNC_W +: POOL_SEL_W];
   assign req_slot   = req_tdata[FUNC_W + POOL_SEL_W +: SLOT_IDX_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   mpfl_pool_table #(
      .NUM_POOLS(NUM_POOLS),
      .POOL_SIZE(POOL_SIZE)
   ) u_pool_table (
      .clock  (clock),
      .reset  (reset),
      .rd_pool(PW'(req_pool)),
      .rd_top (pt_top),
      .rd_low (pt_low),
      .wr_en  (pt_wr_en),
      .wr_pool(pool_ff),
      .wr_top (pt_wr_top),
      .wr_low (pt_wr_low)
   );

   mpfl_slot_store #(
      .NUM_POOLS(NUM_POOLS),
      .POOL_SIZE(POOL_SIZE)
   ) u_slot_store (
      .clock      (clock),
      .rd_en      (mem_rd_en),
      .stk_rd_addr(stk_rd_addr),
      .use_rd_addr(use_rd_addr),
      .stk_q      (stk_q),
      .use_q      (use_q),
      .stk_wr_en  (stk_wr_en),
      .stk_wr_addr(stk_wr_addr),
      .stk_wr_data(stk_wr_data),
      .use_wr_en  (use_wr_en),
      .use_wr_addr(use_wr_addr),
      .use_wr_data(use_wr_data)
   );

   assign slot_sw      = SW'(slot_ff);
   assign mem_rd_en    = (state_ff == S_TOP);
   assign stk_rd_addr  = base_ff + AW'(pt_top - CW'(1));
   assign use_rd_addr  = base_ff + AW'(slot_sw);

   assign rpos         = top_ff - CW'(1);
   assign reset_region = (rpos < low_ff);
   assign got          = reset_region ? SW'(CW'(POOL_SIZE - 1) - rpos) : stk_q;
   assign used         = use_q && (CW'(slot_sw) < (CW'(POOL_SIZE) - low_ff));
   assign finish       = (state_ff == S_MEM) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      r_status    = ST_OK;
      r_index     = slot_sw;
      r_used      = 1'b0;
      r_count     = top_ff;
      pt_wr_en    = 1'b0;
      pt_wr_top   = top_ff;
      pt_wr_low   = low_ff;
      stk_wr_en   = 1'b0;
      stk_wr_addr = base_ff + AW'(top_ff);
      stk_wr_data = slot_sw;
      use_wr_en   = 1'b0;
      use_wr_addr = base_ff + AW'(slot_sw);
      use_wr_data = 1'b0;
      if (pool_bad_ff) begin
         r_status = ST_RANGE;
         r_count  = '0;
      end else if (func_ff == FUNC_ALLOC) begin
         if (top_ff == '0) begin
            r_status = ST_EMPTY;
            r_index  = '0;
            r_count  = '0;
         end else begin
            r_index     = got;
            r_used      = 1'b1;
            r_count     = rpos;
            pt_wr_en    = finish;
            pt_wr_top   = rpos;
            pt_wr_low   = reset_region ? rpos : low_ff;
            use_wr_en   = finish;
            use_wr_addr = base_ff + AW'(got);
            use_wr_data = 1'b1;
         end
      end else if (slot_bad_ff) begin
         r_status = ST_RANGE;
      end else if (func_ff == FUNC_FREE) begin
         if (used && (top_ff < CW'(POOL_SIZE))) begin
            r_count   = top_ff + CW'(1);
            pt_wr_en  = finish;
            pt_wr_top = top_ff + CW'(1);
            stk_wr_en = finish;
            use_wr_en = finish;
         end else begin
            r_status = ST_NOT_USED;
            r_used   = used;
         end
      end else begin
         r_status = used ? ST_OK : ST_NOT_USED;
         r_used   = used;
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      pool_in      = pool_ff;
      slot_in      = slot_ff;
      pool_bad_in  = pool_bad_ff;
      slot_bad_in  = slot_bad_ff;
      base_in      = base_ff;
      top_in       = top_ff;
      low_in       = low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in     = req_func;
               pool_in     = PW'(req_pool);
               slot_in     = req_slot;
               pool_bad_in = (int'(req_pool) >= NUM_POOLS);
               slot_bad_in = (int'(req_slot) >= POOL_SIZE);
               base_in     = AW'(int'(req_pool) * POOL_SIZE);
               state_in    = S_TOP;
            end
         end
         S_TOP: begin
            top_in   = pt_top;
            low_in   = pt_low;
            state_in = S_MEM;
         end
         S_MEM: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {COUNT_W'(r_count), r_used, SLOT_IDX_W'(r_index), r_status};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      pool_ff     <= pool_in;
      slot_ff     <= slot_in;
      pool_bad_ff <= pool_bad_in;
      slot_bad_ff <= slot_bad_in;
      base_ff     <= base_in;
      top_ff      <= top_in;
      low_ff      <= low_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/mpfl_pool_table.sv =====
module mpfl_pool_table #(
   parameter int NUM_POOLS = 8,
   parameter int POOL_SIZE = 1024,
   localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
   localparam int CW = $clog2(POOL_SIZE + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [PW-1:0] rd_pool,
   output logic [CW-1:0] rd_top,
   output logic [CW-1:0] rd_low,
   input  logic          wr_en,
   input  logic [PW-1:0] wr_pool,
   input  logic [CW-1:0] wr_top,
   input  logic [CW-1:0] wr_low
);

   logic [2*CW-1:0]      table_mem [NUM_POOLS];
   logic [NUM_POOLS-1:0] valid_ff;
   logic [2*CW-1:0]      rd_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_pool] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_pool] <= {wr_low, wr_top};
      end
      if (valid_ff[rd_pool]) begin
         rd_q_ff <= table_mem[rd_pool];
      end else begin
         rd_q_ff <= {CW'(POOL_SIZE), CW'(POOL_SIZE)};
      end
   end

   assign rd_top = rd_q_ff[CW-1:0];
   assign rd_low = rd_q_ff[2*CW-1:CW];

endmodule

// ===== design/mpfl_slot_store.sv =====
module mpfl_slot_store #(
   parameter int NUM_POOLS = 8,
   parameter int POOL_SIZE = 1024,
   localparam int SW = $clog2(POOL_SIZE),
   localparam int AW = $clog2(NUM_POOLS * POOL_SIZE)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] stk_rd_addr,
   input  logic [AW-1:0] use_rd_addr,
   output logic [SW-1:0] stk_q,
   output logic          use_q,
   input  logic          stk_wr_en,
   input  logic [AW-1:0] stk_wr_addr,
   input  logic [SW-1:0] stk_wr_data,
   input  logic          use_wr_en,
   input  logic [AW-1:0] use_wr_addr,
   input  logic          use_wr_data
);

   localparam int DEPTH = NUM_POOLS * POOL_SIZE;

   logic [SW-1:0] stack_mem [DEPTH];
   logic          use_mem   [DEPTH];
   logic [SW-1:0] stk_q_ff;
   logic          use_q_ff;

   always_ff @(posedge clock) begin
      if (stk_wr_en) begin
         stack_mem[stk_wr_addr] <= stk_wr_data;
      end
      if (rd_en) begin
         stk_q_ff <= stack_mem[stk_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (use_wr_en) begin
         use_mem[use_wr_addr] <= use_wr_data;
      end
      if (rd_en) begin
         use_q_ff <= use_mem[use_rd_addr];
      end
   end

   assign stk_q = stk_q_ff;
   assign use_q = use_q_ff;

endmodule

// ===== design/mpfl_checker.sv =====
module mpfl_checker
   import mpfl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   status_type rsp_status;

   assign rsp_status = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == ST_EMPTY) |->
         (rsp_tdata[RSP_DATA_W-1:RSP_INDEX_LSB] == '0))
      else $error("empty-pool response carries nonzero fields");

   a_range_not_used: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == ST_RANGE) |-> !rsp_tdata[RSP_USED_BIT])
      else $error("out-of-range response reports slot in use");

   logic unused_req;
   assign unused_req = ^req_tdata;

endmodule

bind multi_pool_free_list_allocator mpfl_checker u_mpfl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
